// ----- src/qoi_pixel_encoder_unit_defines.svh -----
`ifndef QOI_PIXEL_ENCODER_UNIT_DEFINES_SVH
`define QOI_PIXEL_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define QPE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define QPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/qpe_pkg.sv -----
`default_nettype none

package qpe_pkg;

    localparam int INDEX_DEPTH = 64;
    localparam int SLOT_W      = $clog2(INDEX_DEPTH);
    localparam int QPE_QUEUE_DEPTH = 4;

    localparam logic [7:0] OP_RGB   = 8'hFE;
    localparam logic [7:0] OP_RGBA  = 8'hFF;
    localparam logic [1:0] TAG_INDEX = 2'b00;
    localparam logic [1:0] TAG_DIFF  = 2'b01;
    localparam logic [1:0] TAG_LUMA  = 2'b10;
    localparam logic [1:0] TAG_RUN   = 2'b11;

    localparam logic [5:0] RUN_MAX = 6'd62;

    localparam logic [5:0] HASH_R = 6'd3;
    localparam logic [5:0] HASH_G = 6'd5;
    localparam logic [5:0] HASH_B = 6'd7;
    localparam logic [5:0] HASH_A = 6'd11;

    localparam logic [7:0] DIFF_BIAS = 8'd2;
    localparam logic [7:0] LUMA_G_BIAS = 8'd32;
    localparam logic [7:0] LUMA_RB_BIAS = 8'd8;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       final_pixel;
    } pixel_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       item_done;
    } chunk_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } color_t;

    localparam color_t DEFAULT_COLOR = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_INDEX,
        KIND_DIFF,
        KIND_LUMA,
        KIND_RGB,
        KIND_RGBA
    } op_kind_t;

    // One pixel's worth of output, as handed from front to back.
    typedef struct packed {
        logic       has_run;
        logic [5:0] run_code;
        op_kind_t   kind;
        logic [7:0] head;
        logic [7:0] second;
        color_t     color;
    } op_desc_t;

endpackage

`default_nettype wire

// ----- src/qoi_pixel_encoder_unit.sv -----
`default_nettype none
`include "qoi_pixel_encoder_unit_defines.svh"

// QOI chunk encoder for one RGBA pixel per request. A pixel whose chunk is one
// byte, or a repeat that emits nothing, goes through at one per cycle while
// chunk_stall is low; the output side moves one byte per cycle unless
// chunk_stall holds it, and a pixel emits up to 6 bytes (RGBA with a flushed
// run being the longest). The front keeps the previous pixel, the run count
// and the 64-entry color index, reads the index at the edge that takes the
// pixel and commits the op from its stage 1 registers once the queue has
// room; the op then passes through the queue to the output register. A
// queue of QueueDepth ops lets the front run ahead while the byte serializer
// drains multi-byte chunks. The index clears at reset through per-entry valid
// bits, so no clearing pass is needed.
// alpha_present (reset 1) forces alpha to 255 when low; write it only while
// idle. item_done marks the last byte of each pixel that emits any bytes.
module qoi_pixel_encoder_unit #(
    parameter int QueueDepth = qpe_pkg::QPE_QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pixel_valid,
    output logic             pixel_stall,
    input  qpe_pkg::pixel_t  pixel,
    output logic             chunk_valid,
    input  wire logic        chunk_stall,
    output qpe_pkg::chunk_t  chunk,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data
);
    import qpe_pkg::*;

    logic      alpha_present_reg;
    logic      q_full;
    logic      q_empty;
    logic      push;
    logic      pop;
    op_desc_t  push_desc;
    op_desc_t  head_desc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_present_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            alpha_present_reg <= cfg_data;
        end
    end

    qpe_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel_valid   (pixel_valid),
        .pixel_stall   (pixel_stall),
        .pixel         (pixel),
        .alpha_present (alpha_present_reg),
        .q_full        (q_full),
        .push          (push),
        .push_desc     (push_desc)
    );

    qpe_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .full      (q_full),
        .empty     (q_empty)
    );

    qpe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .head_desc   (head_desc),
        .pop         (pop),
        .chunk_valid (chunk_valid),
        .chunk_stall (chunk_stall),
        .chunk       (chunk)
    );

    `QPE_ASSERT_NOW(a_no_overflow, push, !q_full, "op pushed into a full queue")
    `QPE_ASSERT_NOW(a_no_underflow, pop, !q_empty, "op popped from an empty queue")
    `QPE_ASSERT_NEXT(a_back_busy, !q_empty && !chunk_valid, chunk_valid, "serializer idle")

endmodule

`default_nettype wire

// ----- src/qpe_queue.sv -----
`default_nettype none

module qpe_queue #(
    parameter int Depth = qpe_pkg::QPE_QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  qpe_pkg::op_desc_t      push_desc,
    input  wire logic              pop,
    output qpe_pkg::op_desc_t      head_desc,
    output logic                   full,
    output logic                   empty
);
    import qpe_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    op_desc_t            entry_reg [Depth];
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]     count_reg, count_next;

    assign full      = count_reg == CntW'(Depth);
    assign empty     = count_reg == '0;
    assign head_desc = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

// ----- src/qpe_front.sv -----
`default_nettype none

module qpe_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          pixel_valid,
    output logic               pixel_stall,
    input  qpe_pkg::pixel_t    pixel,
    input  wire logic          alpha_present,
    input  wire logic          q_full,
    output logic               push,
    output qpe_pkg::op_desc_t  push_desc
);
    import qpe_pkg::*;

    // Color index: memory plus per-entry valid bits (cleared entries read as zero)
    color_t                  idx_mem [INDEX_DEPTH];
    logic [INDEX_DEPTH-1:0]  idx_vld_reg;

    // Stage 1: accepted pixel and its index read
    logic               s1_valid_reg, s1_valid_next;
    color_t             s1_color_reg;
    logic               s1_last_reg;
    logic [SLOT_W-1:0]  s1_slot_reg;
    color_t             rd_data_reg;
    logic               rd_vld_reg;
    logic               byp_reg;
    color_t             byp_data_reg;

    // Encoder state
    color_t             prev_reg, prev_next;
    logic [5:0]         run_reg, run_next;
    logic               first_reg;

    color_t             in_color;
    logic [SLOT_W-1:0]  in_slot;
    logic               accept;
    logic               commit;
    logic               idx_we;
    color_t             entry;
    logic               same;
    logic               hit;
    logic [5:0]         run_inc;
    logic [7:0]         dr, dg, db, gd, lg, lr, lb;
    op_desc_t           desc;

    assign pixel_stall = s1_valid_reg && q_full;
    assign accept      = pixel_valid && !pixel_stall;
    assign commit      = s1_valid_reg && !q_full;

    always_comb
    begin
        in_color.r = pixel.red;
        in_color.g = pixel.green;
        in_color.b = pixel.blue;
        in_color.a = alpha_present ? pixel.alpha : 8'hFF;
        in_slot = in_color.r[5:0] * HASH_R + in_color.g[5:0] * HASH_G
                + in_color.b[5:0] * HASH_B + in_color.a[5:0] * HASH_A;
    end

    // Forward a write that lands in the same edge as the read
    assign entry = byp_reg ? byp_data_reg : (rd_vld_reg ? rd_data_reg : '0);

    assign same    = s1_color_reg == prev_reg;
    assign hit     = entry == s1_color_reg;
    assign run_inc = run_reg + 6'd1;

    always_comb
    begin
        dr = s1_color_reg.r - prev_reg.r + DIFF_BIAS;
        dg = s1_color_reg.g - prev_reg.g + DIFF_BIAS;
        db = s1_color_reg.b - prev_reg.b + DIFF_BIAS;
        gd = s1_color_reg.g - prev_reg.g;
        lg = gd + LUMA_G_BIAS;
        lr = s1_color_reg.r - prev_reg.r - gd + LUMA_RB_BIAS;
        lb = s1_color_reg.b - prev_reg.b - gd + LUMA_RB_BIAS;
    end

    always_comb
    begin
        desc.has_run  = 1'b0;
        desc.run_code = '0;
        desc.kind     = KIND_NONE;
        desc.head     = '0;
        desc.second   = '0;
        desc.color    = s1_color_reg;
        prev_next     = prev_reg;
        run_next      = run_reg;
        idx_we        = 1'b0;

        if (same)
        begin
            run_next = run_inc;
            idx_we   = first_reg;
            if (run_inc == RUN_MAX)
            begin
                desc.has_run  = 1'b1;
                desc.run_code = RUN_MAX - 6'd1;
                run_next      = '0;
            end
        end
        else
        begin
            prev_next = s1_color_reg;
            run_next  = '0;
            if (run_reg != '0)
            begin
                desc.has_run  = 1'b1;
                desc.run_code = run_reg - 6'd1;
            end
            if (hit)
            begin
                desc.kind = KIND_INDEX;
                desc.head = {TAG_INDEX, s1_slot_reg};
            end
            else
            begin
                idx_we = 1'b1;
                priority if (s1_color_reg.a != prev_reg.a)
                begin
                    desc.kind = KIND_RGBA;
                    desc.head = OP_RGBA;
                end
                else if (dr <= 8'd3 && dg <= 8'd3 && db <= 8'd3)
                begin
                    desc.kind = KIND_DIFF;
                    desc.head = {TAG_DIFF, dr[1:0], dg[1:0], db[1:0]};
                end
                else if (lg <= 8'd63 && lr <= 8'd15 && lb <= 8'd15)
                begin
                    desc.kind   = KIND_LUMA;
                    desc.head   = {TAG_LUMA, lg[5:0]};
                    desc.second = {lr[3:0], lb[3:0]};
                end
                else
                begin
                    desc.kind = KIND_RGB;
                    desc.head = OP_RGB;
                end
            end
        end

        // Flush a pending run on the last pixel
        if (s1_last_reg && run_next != '0)
        begin
            desc.has_run  = 1'b1;
            desc.run_code = run_next - 6'd1;
            run_next      = '0;
        end
    end

    assign push      = commit && (desc.has_run || desc.kind != KIND_NONE);
    assign push_desc = desc;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (commit)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            prev_reg     <= DEFAULT_COLOR;
            run_reg      <= '0;
            first_reg    <= 1'b1;
            idx_vld_reg  <= '0;
            rd_vld_reg   <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (commit)
            begin
                prev_reg  <= prev_next;
                run_reg   <= run_next;
                first_reg <= 1'b0;
                if (idx_we)
                begin
                    idx_vld_reg[s1_slot_reg] <= 1'b1;
                end
            end
            if (accept)
            begin
                rd_vld_reg <= idx_vld_reg[in_slot];
                byp_reg    <= commit && idx_we && (s1_slot_reg == in_slot);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_color_reg <= in_color;
            s1_last_reg  <= pixel.final_pixel;
            s1_slot_reg  <= in_slot;
            rd_data_reg  <= idx_mem[in_slot];
            byp_data_reg <= s1_color_reg;
        end
        if (commit && idx_we)
        begin
            idx_mem[s1_slot_reg] <= s1_color_reg;
        end
    end

endmodule

`default_nettype wire

// ----- src/qpe_back.sv -----
`default_nettype none

module qpe_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  qpe_pkg::op_desc_t  head_desc,
    output logic               pop,
    output logic               chunk_valid,
    input  wire logic          chunk_stall,
    output qpe_pkg::chunk_t    chunk
);
    import qpe_pkg::*;

    logic        out_valid_reg, out_valid_next;
    chunk_t      out_reg;
    logic [2:0]  pos_reg, pos_next;
    logic [2:0]  op_len;
    logic [2:0]  total;
    logic [2:0]  op_pos;
    logic        last;
    logic        load;
    logic [7:0]  op_byte;
    logic [7:0]  cur_byte;

    always_comb
    begin
        unique case (head_desc.kind)
            KIND_NONE:  op_len = 3'd0;
            KIND_INDEX: op_len = 3'd1;
            KIND_DIFF:  op_len = 3'd1;
            KIND_LUMA:  op_len = 3'd2;
            KIND_RGB:   op_len = 3'd4;
            KIND_RGBA:  op_len = 3'd5;
            default:    op_len = 3'd0;
        endcase
    end

    assign total  = op_len + {2'b00, head_desc.has_run};
    assign op_pos = pos_reg - {2'b00, head_desc.has_run};
    assign last   = pos_reg == total - 3'd1;

    always_comb
    begin
        unique case (op_pos)
            3'd0:    op_byte = head_desc.head;
            3'd1:    op_byte = (head_desc.kind == KIND_LUMA) ? head_desc.second
                                                             : head_desc.color.r;
            3'd2:    op_byte = head_desc.color.g;
            3'd3:    op_byte = head_desc.color.b;
            3'd4:    op_byte = head_desc.color.a;
            default: op_byte = head_desc.head;
        endcase
        if (head_desc.has_run && pos_reg == 3'd0)
        begin
            cur_byte = {TAG_RUN, head_desc.run_code};
        end
        else
        begin
            cur_byte = op_byte;
        end
    end

    // Load the next byte whenever the output register is free or draining
    assign load = !q_empty && (!out_valid_reg || !chunk_stall);
    assign pop  = load && last;

    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            pos_next       = last ? 3'd0 : pos_reg + 3'd1;
            out_valid_next = 1'b1;
        end
        else if (!chunk_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.out_byte  <= cur_byte;
            out_reg.item_done <= last;
        end
    end

    assign chunk_valid = out_valid_reg;
    assign chunk       = out_reg;

endmodule

`default_nettype wire
